[rtl/core/lifetime_aware_best_fit_offset_alloc_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the best-fit offset allocator
// Short forms for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef LIFETIME_AWARE_BEST_FIT_OFFSET_ALLOC_MACROS_SVH
`define LIFETIME_AWARE_BEST_FIT_OFFSET_ALLOC_MACROS_SVH

// A condition that must never be seen outside reset.
`define LBFA_ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("lbfa check failed");

// A condition that implies another in the same cycle.
`define LBFA_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lbfa check failed");

// A condition that implies another in the next cycle.
`define LBFA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lbfa check failed");

`endif

[rtl/core/lbfa_pkg.sv]
// ----------------------------------------------------------------------------
// lbfa_pkg
// Shared constants, cell word types and cell operation codes.
// ----------------------------------------------------------------------------
package lbfa_pkg;

   localparam int MAX_BUFFERS = 64;
   localparam int POS_BITS    = 16;
   localparam int IDX_W       = $clog2(MAX_BUFFERS);
   localparam int CNT_W       = $clog2(MAX_BUFFERS + 1);
   localparam int BYTES_W     = 32;
   localparam int SIZE_W      = 33;
   localparam int OFS_W       = 39;
   localparam int ALIGN_W     = 17;
   localparam int BASE_W      = 40;
   localparam int ADDR_W      = 41;
   localparam int CSR_IDX_W   = 2;
   localparam int DIV_STEPS   = BYTES_W;
   localparam int STEP_W      = $clog2(DIV_STEPS);

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_ALIGNMENT    = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_ADDRESS = CSR_IDX_W'(1);

   // Load ring cell operations.
   localparam logic [1:0] LOP_HOLD  = 2'd0;
   localparam logic [1:0] LOP_SHIFT = 2'd1;
   localparam logic [1:0] LOP_WRITE = 2'd2;
   localparam logic [1:0] LOP_MARK  = 2'd3;

   // Offset-sorted chain cell operations.
   localparam logic [1:0] SOP_HOLD   = 2'd0;
   localparam logic [1:0] SOP_SHIFT  = 2'd1;
   localparam logic [1:0] SOP_INSERT = 2'd2;
   localparam logic [1:0] SOP_CLEAR  = 2'd3;

   typedef struct packed {
      logic [SIZE_W-1:0]   size;
      logic [POS_BITS-1:0] life_begin;
      logic [POS_BITS-1:0] life_end;
      logic [OFS_W-1:0]    offset;
   } data_type;

   typedef struct packed {
      logic     flag;
      data_type data;
   } slot_type;

   typedef struct packed {
      logic [1:0] op;
      data_type   wr_data;
   } load_ctl_type;

   typedef struct packed {
      logic [1:0] op;
      data_type   new_data;
   } sort_ctl_type;

endpackage

[rtl/core/lbfa_round.sv]
// ----------------------------------------------------------------------------
// lbfa_round
// Rounds a byte size up to the alignment with a bit-serial remainder unit.
// ----------------------------------------------------------------------------
module lbfa_round import lbfa_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [BYTES_W-1:0] bytes,
   input  logic [ALIGN_W-1:0] align,
   output logic               done,
   output logic [SIZE_W-1:0]  aligned
);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [STEP_W-1:0]  cnt_ff, cnt_in;
   logic [BYTES_W-1:0] bits_ff, bits_in;
   logic [BYTES_W-1:0] keep_ff, keep_in;
   logic [ALIGN_W:0]   rem_ff, rem_in;
   logic [ALIGN_W:0]   divisor;
   logic [ALIGN_W:0]   trial;

   // A zero alignment behaves as one.
   assign divisor = (align == '0) ? (ALIGN_W+1)'(1) : {1'b0, align};
   assign trial   = {rem_ff[ALIGN_W-1:0], bits_ff[BYTES_W-1]};

   // One quotient bit per cycle, most significant first.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      bits_in = bits_ff;
      keep_in = keep_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         bits_in = bytes;
         keep_in = bytes;
         rem_in  = '0;
      end else if (busy_ff) begin
         rem_in  = (trial >= divisor) ? trial - divisor : trial;
         bits_in = {bits_ff[BYTES_W-2:0], 1'b0};
         cnt_in  = cnt_ff + STEP_W'(1);
         if (cnt_ff == STEP_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      bits_ff <= bits_in;
      keep_ff <= keep_in;
      rem_ff  <= rem_in;
   end

   assign done    = done_ff;
   assign aligned = (rem_ff == '0) ? SIZE_W'(keep_ff)
                                   : SIZE_W'(keep_ff) + SIZE_W'(divisor) - SIZE_W'(rem_ff);

endmodule

[rtl/core/lbfa_load_cell.sv]
// ----------------------------------------------------------------------------
// lbfa_load_cell
// One cell of the load-order ring: a buffer's size, lifetime and offset.
// ----------------------------------------------------------------------------
module lbfa_load_cell import lbfa_pkg::*; (
   input  logic         clock,
   input  load_ctl_type ctl,
   input  slot_type     right_slot,
   output slot_type     slot
);

   slot_type slot_ff, slot_in;

   // The flag marks a buffer already placed in this set.
   always_comb begin
      slot_in = slot_ff;
      unique case (ctl.op)
         LOP_HOLD:  slot_in = slot_ff;
         LOP_SHIFT: slot_in = right_slot;
         LOP_WRITE: begin
            slot_in.flag = 1'b0;
            slot_in.data = ctl.wr_data;
         end
         LOP_MARK: begin
            slot_in.flag        = 1'b1;
            slot_in.data.offset = ctl.wr_data.offset;
         end
         default: slot_in = slot_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

   assign slot = slot_ff;

endmodule

[rtl/core/lbfa_sort_cell.sv]
// ----------------------------------------------------------------------------
// lbfa_sort_cell
// One cell of the chain of placed buffers kept in ascending offset order.
// ----------------------------------------------------------------------------
module lbfa_sort_cell import lbfa_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  sort_ctl_type ctl,
   input  slot_type     left_slot,
   input  logic         left_ge,
   input  slot_type     right_slot,
   output slot_type     slot,
   output logic         ge
);

   logic     valid_ff, valid_in;
   data_type data_ff, data_in;

   // An empty cell, or one at or above the new offset, yields its place.
   assign ge = !valid_ff || (data_ff.offset >= ctl.new_data.offset);

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      unique case (ctl.op)
         SOP_HOLD: begin
            valid_in = valid_ff;
         end
         SOP_SHIFT: begin
            valid_in = right_slot.flag;
            data_in  = right_slot.data;
         end
         SOP_INSERT: begin
            if (left_ge) begin
               valid_in = left_slot.flag;
               data_in  = left_slot.data;
            end else if (ge) begin
               valid_in = 1'b1;
               data_in  = ctl.new_data;
            end
         end
         SOP_CLEAR: begin
            valid_in = 1'b0;
         end
         default: valid_in = valid_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign slot = '{flag: valid_ff, data: data_ff};

endmodule

[rtl/core/lifetime_aware_best_fit_offset_alloc.sv]
// ----------------------------------------------------------------------------
// lifetime_aware_best_fit_offset_alloc
// Lifetime-aware best-fit offset assignment over a set of buffers.
// ----------------------------------------------------------------------------
// Usage: buffers arrive as words on the req_ channel, one per handshake, with
// a byte size and a lifetime. Each size is rounded up to the alignment by a
// bit-serial remainder unit; req_stall is high during that time.
// The word marked final_buffer closes the set. The set is then placed in
// descending size order: each placement spends one revolution of the
// load-order ring finding the next buffer, one revolution of the
// offset-sorted chain finding the tightest gap, and an insert step.
// Results leave on the rsp_ channel, one word per buffer in load order; the
// ring advances only when a word is taken, so rsp_stall simply holds the
// current word. After the last word the ring is turned back into place and
// the block accepts the next set.
// The csr_ port writes the alignment and base address; it is always ready.
// Reset empties the set and restores alignment 16 and base address 0.
// ----------------------------------------------------------------------------
`include "lifetime_aware_best_fit_offset_alloc_macros.svh"

module lifetime_aware_best_fit_offset_alloc import lbfa_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [BYTES_W-1:0]   req_buffer_bytes,
   input  logic [15:0]          req_first_use,
   input  logic [15:0]          req_last_use,
   input  logic                 req_final_buffer,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [IDX_W-1:0]     rsp_buffer_index,
   output logic [ADDR_W-1:0]    rsp_address,
   output logic [OFS_W-1:0]     rsp_peak_bytes,
   output logic                 rsp_overflowed,
   output logic                 rsp_last_result,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [BASE_W-1:0]    csr_wdata
);

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_DIV     = 3'd1;
   localparam logic [2:0] ST_SEL     = 3'd2;
   localparam logic [2:0] ST_SCAN    = 3'd3;
   localparam logic [2:0] ST_INS     = 3'd4;
   localparam logic [2:0] ST_EMIT    = 3'd5;
   localparam logic [2:0] ST_REALIGN = 3'd6;

   logic [2:0]          state_ff, state_in;
   logic [ALIGN_W-1:0]  align_ff, align_in;
   logic [BASE_W-1:0]   base_ff, base_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                ovf_ff, ovf_in;
   logic [CNT_W-1:0]    step_ff, step_in;
   logic [CNT_W-1:0]    placed_ff, placed_in;
   logic [POS_BITS-1:0] in_begin_ff, in_begin_in;
   logic [POS_BITS-1:0] in_end_ff, in_end_in;
   logic                in_final_ff, in_final_in;
   logic                sel_found_ff, sel_found_in;
   logic [IDX_W-1:0]    sel_idx_ff, sel_idx_in;
   data_type            sel_ff, sel_in;
   logic                fit_found_ff, fit_found_in;
   logic [OFS_W-1:0]    prev_ff, prev_in;
   logic [OFS_W-1:0]    best_ff, best_in;
   logic [OFS_W-1:0]    best_gap_ff, best_gap_in;
   logic [OFS_W-1:0]    peak_ff, peak_in;

   logic                req_take, rsp_take;
   logic                div_start, div_done;
   logic [SIZE_W-1:0]   div_aligned;
   logic                ring_shift;

   slot_type            load_slot [MAX_BUFFERS];
   load_ctl_type        load_ctl  [MAX_BUFFERS];
   slot_type            sort_slot [MAX_BUFFERS];
   logic [MAX_BUFFERS-1:0] sort_ge;
   logic [MAX_BUFFERS-1:0] sort_valid;
   sort_ctl_type        sort_ctl;

   slot_type            lhead, shead;
   logic [POS_BITS-1:0] ov_lo, ov_hi;
   logic                overlap;
   logic [OFS_W-1:0]    gap, pe, best_final, place_end;
   logic                fits;

   assign req_take  = req_valid && !req_stall;
   assign rsp_take  = rsp_valid && !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;

   // Configuration registers.
   always_comb begin
      align_in = align_ff;
      base_in  = base_ff;
      if (csr_valid && csr_ready) begin
         if (csr_index == CSR_ALIGNMENT) begin
            align_in = csr_wdata[ALIGN_W-1:0];
         end else if (csr_index == CSR_BASE_ADDRESS) begin
            base_in = csr_wdata;
         end
      end
   end

   assign div_start = req_take && (count_ff != CNT_W'(MAX_BUFFERS));

   lbfa_round u_round (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .bytes   (req_buffer_bytes),
      .align   (align_ff),
      .done    (div_done),
      .aligned (div_aligned)
   );

   assign lhead = load_slot[0];
   assign shead = sort_slot[0];

   // Overlap and gap tests against the head of the sorted chain.
   assign ov_lo   = (sel_ff.life_begin > shead.data.life_begin) ? sel_ff.life_begin
                                                               : shead.data.life_begin;
   assign ov_hi   = (sel_ff.life_end < shead.data.life_end) ? sel_ff.life_end
                                                           : shead.data.life_end;
   assign overlap = shead.flag && (ov_lo < ov_hi);
   assign gap     = shead.data.offset - prev_ff;
   assign fits    = (shead.data.offset >= prev_ff) && (gap >= OFS_W'(sel_ff.size))
                    && (!fit_found_ff || (gap < best_gap_ff));
   assign pe      = shead.data.offset + OFS_W'(shead.data.size);

   assign best_final = fit_found_ff ? best_ff : prev_ff;
   assign place_end  = best_final + OFS_W'(sel_ff.size);

   assign ring_shift = (state_ff == ST_SEL) || rsp_take
                       || ((state_ff == ST_REALIGN) && (step_ff != CNT_W'(MAX_BUFFERS)));

   // Sequencer of the load, placement and result phases.
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      step_in      = step_ff;
      placed_in    = placed_ff;
      in_begin_in  = in_begin_ff;
      in_end_in    = in_end_ff;
      in_final_in  = in_final_ff;
      sel_found_in = sel_found_ff;
      sel_idx_in   = sel_idx_ff;
      sel_in       = sel_ff;
      fit_found_in = fit_found_ff;
      prev_in      = prev_ff;
      best_in      = best_ff;
      best_gap_in  = best_gap_ff;
      peak_in      = peak_ff;
      sort_ctl.op       = SOP_HOLD;
      sort_ctl.new_data = sel_ff;
      sort_ctl.new_data.offset = best_final;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               in_begin_in = req_first_use[POS_BITS-1:0];
               in_end_in   = req_last_use[POS_BITS-1:0];
               in_final_in = req_final_buffer;
               if (count_ff != CNT_W'(MAX_BUFFERS)) begin
                  state_in = ST_DIV;
               end else begin
                  ovf_in = 1'b1;
                  if (req_final_buffer) begin
                     state_in     = ST_SEL;
                     step_in      = '0;
                     placed_in    = '0;
                     peak_in      = '0;
                     sel_found_in = 1'b0;
                  end
               end
            end
         end
         ST_DIV: begin
            if (div_done) begin
               count_in = count_ff + CNT_W'(1);
               if (in_final_ff) begin
                  state_in     = ST_SEL;
                  step_in      = '0;
                  placed_in    = '0;
                  peak_in      = '0;
                  sel_found_in = 1'b0;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_SEL: begin
            // Largest unplaced buffer; the first one seen wins a tie.
            if ((step_ff < count_ff) && !lhead.flag
                && (!sel_found_ff || (lhead.data.size > sel_ff.size))) begin
               sel_found_in = 1'b1;
               sel_idx_in   = step_ff[IDX_W-1:0];
               sel_in       = lhead.data;
            end
            step_in = step_ff + CNT_W'(1);
            if (step_ff == CNT_W'(MAX_BUFFERS - 1)) begin
               state_in     = ST_SCAN;
               step_in      = '0;
               prev_in      = '0;
               fit_found_in = 1'b0;
            end
         end
         ST_SCAN: begin
            sort_ctl.op = SOP_SHIFT;
            if (overlap) begin
               if (fits) begin
                  fit_found_in = 1'b1;
                  best_gap_in  = gap;
                  best_in      = prev_ff;
               end
               if (pe > prev_ff) begin
                  prev_in = pe;
               end
            end
            step_in = step_ff + CNT_W'(1);
            if (step_ff == CNT_W'(MAX_BUFFERS - 1)) begin
               state_in = ST_INS;
            end
         end
         ST_INS: begin
            sort_ctl.op = SOP_INSERT;
            if (place_end > peak_ff) begin
               peak_in = place_end;
            end
            placed_in = placed_ff + CNT_W'(1);
            step_in   = '0;
            if (placed_ff + CNT_W'(1) == count_ff) begin
               state_in = ST_EMIT;
            end else begin
               state_in     = ST_SEL;
               sel_found_in = 1'b0;
            end
         end
         ST_EMIT: begin
            if (rsp_take) begin
               step_in = step_ff + CNT_W'(1);
               if (step_ff + CNT_W'(1) == count_ff) begin
                  state_in = ST_REALIGN;
               end
            end
         end
         ST_REALIGN: begin
            if (step_ff == CNT_W'(MAX_BUFFERS)) begin
               sort_ctl.op = SOP_CLEAR;
               count_in    = '0;
               ovf_in      = 1'b0;
               state_in    = ST_IDLE;
            end else begin
               step_in = step_ff + CNT_W'(1);
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Load-order ring: write at the fill position, mark at the selected one.
   for (genvar k = 0; k < MAX_BUFFERS; k++) begin : g_load
      always_comb begin
         load_ctl[k].wr_data = '{size: div_aligned, life_begin: in_begin_ff,
                                 life_end: in_end_ff, offset: best_final};
         if (ring_shift) begin
            load_ctl[k].op = LOP_SHIFT;
         end else if (div_done && (count_ff == CNT_W'(k))) begin
            load_ctl[k].op = LOP_WRITE;
         end else if ((state_ff == ST_INS) && (sel_idx_ff == IDX_W'(k))) begin
            load_ctl[k].op = LOP_MARK;
         end else begin
            load_ctl[k].op = LOP_HOLD;
         end
      end

      lbfa_load_cell u_load_cell (
         .clock      (clock),
         .ctl        (load_ctl[k]),
         .right_slot (load_slot[(k + 1) % MAX_BUFFERS]),
         .slot       (load_slot[k])
      );
   end

   // Offset-sorted chain of placed buffers.
   for (genvar k = 0; k < MAX_BUFFERS; k++) begin : g_sort
      lbfa_sort_cell u_sort_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (sort_ctl),
         .left_slot  (sort_slot[(k + MAX_BUFFERS - 1) % MAX_BUFFERS]),
         .left_ge    ((k == 0) ? 1'b0 : sort_ge[(k + MAX_BUFFERS - 1) % MAX_BUFFERS]),
         .right_slot (sort_slot[(k + 1) % MAX_BUFFERS]),
         .slot       (sort_slot[k]),
         .ge         (sort_ge[k])
      );
      assign sort_valid[k] = sort_slot[k].flag;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         align_ff     <= ALIGN_W'(16);
         base_ff      <= '0;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         step_ff      <= '0;
         placed_ff    <= '0;
         sel_found_ff <= 1'b0;
         fit_found_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         align_ff     <= align_in;
         base_ff      <= base_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         step_ff      <= step_in;
         placed_ff    <= placed_in;
         sel_found_ff <= sel_found_in;
         fit_found_ff <= fit_found_in;
      end
   end

   always_ff @(posedge clock) begin
      in_begin_ff <= in_begin_in;
      in_end_ff   <= in_end_in;
      in_final_ff <= in_final_in;
      sel_idx_ff  <= sel_idx_in;
      sel_ff      <= sel_in;
      prev_ff     <= prev_in;
      best_ff     <= best_in;
      best_gap_ff <= best_gap_in;
      peak_ff     <= peak_in;
   end

   // Result word straight from the head of the load-order ring.
   assign rsp_valid        = (state_ff == ST_EMIT);
   assign rsp_buffer_index = step_ff[IDX_W-1:0];
   assign rsp_address      = ADDR_W'(lhead.data.offset) + ADDR_W'(base_ff);
   assign rsp_peak_bytes   = peak_ff;
   assign rsp_overflowed   = ovf_ff;
   assign rsp_last_result  = (step_ff + CNT_W'(1) == count_ff);

   `LBFA_ASSERT_NEVER(a_count_bound, clock, reset, count_ff > CNT_W'(MAX_BUFFERS))
   `LBFA_ASSERT_IMPLY(a_emit_in_set, clock, reset, rsp_valid, step_ff < count_ff)
   `LBFA_ASSERT_IMPLY(a_chain_fill, clock, reset, state_ff == ST_SCAN,
      $countones(sort_valid) == 32'(placed_ff))
   `LBFA_ASSERT_NEXT(a_last_ends_set, clock, reset, rsp_take && rsp_last_result,
      state_ff == ST_REALIGN)

endmodule
